// ===== rtl/lpcsyn_pkg.sv =====
// Shared types and constants for the LPC all-pole synthesis filter.
// Used by lpcsyn_ctrl, lpcsyn_mac and lpc_all_pole_synthesis_filter; no dependencies.
package lpcsyn_pkg;

	// Filter order (1..10) and derived tap index width
	localparam int ORDER = 10;
	localparam int IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;

	// Field widths
	localparam int COEF_W     = 16;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int DATA_W     = 32;
	localparam int MUL_A_W    = 17;
	localparam int MUL_B_W    = 32;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;
	localparam int COEF_VEC_W = 160;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 8'd3;

	// Rounding shifts: g*x has 25 fraction bits, a*y has 26, y*32767 has 15 over integer
	localparam logic [3:0] SH_GAIN  = 4'd10;
	localparam logic [3:0] SH_TAP   = 4'd11;
	localparam logic [3:0] SH_SCALE = 4'd15;

	// Output scale factor
	localparam logic signed [MUL_A_W-1:0] SCALE_K = 17'sd32767;

	// Operation carried through the shared multiply-accumulate unit
	typedef enum logic [1:0] {
		OP_GAIN,
		OP_TAP,
		OP_SCALE
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_HOLD,
		ST_TAP,
		ST_SCALE
	} state_t;

	// Tag that travels with one operation through the unit
	typedef struct packed {
		logic             vld;
		op_t              op;
		logic [IDX_W-1:0] idx;
	} mac_tag_t;

endpackage

// ===== rtl/lpc_all_pole_synthesis_filter.sv =====
// LPC all-pole synthesis filter, order 10, transposed direct form II. One excitation
// sample per transaction gives one output sample. An item runs from acceptance to
// result as one gain multiply, a hold step while y is written back, ten tap
// multiplies and one output scale multiply, all through a single registered
// 17x32 multiply-accumulate unit. The next item is accepted in the cycle after the
// last multiply is issued, so a new item is not taken before the last is through.
// The finished sample sits in an output register; if it is not taken, the block
// still accepts and processes the next item up to its output scale step, where
// it waits. Filter memory clears at reset only and carries across frames.
// The user must write configuration only while idle; the block does not enforce it.
// Depends on lpcsyn_pkg, lpcsyn_ctrl and lpcsyn_mac.
module lpc_all_pole_synthesis_filter import lpcsyn_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	// Excitation input
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] excitation,
	// Speech output
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] speech_sample,
	output logic                       clipped
);

	logic [63:0]                coef_first_q;
	logic [63:0]                coef_middle_q;
	logic [31:0]                coef_last_q;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [DATA_W-1:0]   y_q;
	logic signed [DATA_W-1:0]   mem_q [ORDER];
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] speech_q;
	logic                       clip_q;

	logic [COEF_VEC_W-1:0]      coef_vec;
	logic signed [COEF_W-1:0]   coef_sel;
	mac_tag_t                   issue;
	mac_tag_t                   wb;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [DATA_W-1:0]   addend;
	logic [IDX_W-1:0]           nxt_idx;
	logic signed [DATA_W-1:0]   mac_result;
	logic signed [SAMPLE_W-1:0] mac_sample;
	logic                       mac_clip;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_first_q  <= '0;
			coef_middle_q <= '0;
			coef_last_q   <= '0;
			gain_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COEF_FIRST:  coef_first_q  <= cfg_data;
				REG_COEF_MIDDLE: coef_middle_q <= cfg_data;
				REG_COEF_LAST:   coef_last_q   <= cfg_data[31:0];
				REG_GAIN:        gain_q        <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q <= excitation;
		end
	end

	lpcsyn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_valid_q),
		.in_ready (in_ready),
		.issue    (issue)
	);

	// Operand selection for the issued operation
	assign coef_vec = {coef_last_q, coef_middle_q, coef_first_q};
	assign coef_sel = coef_vec[COEF_W*issue.idx +: COEF_W];

	always_comb begin
		case (issue.op)
			OP_GAIN: begin
				mul_a = $signed({1'b0, gain_q});
				mul_b = MUL_B_W'(x_q);
			end
			OP_TAP: begin
				mul_a = MUL_A_W'(coef_sel);
				mul_b = y_q;
			end
			OP_SCALE: begin
				mul_a = SCALE_K;
				mul_b = y_q;
			end
			default: begin
				mul_a = '0;
				mul_b = y_q;
			end
		endcase
	end

	// Addend for the operation in write-back; last tap has none
	assign nxt_idx = (wb.idx == IDX_W'(ORDER - 1)) ? wb.idx : wb.idx + 1'b1;

	always_comb begin
		case (wb.op)
			OP_GAIN:  addend = mem_q[0];
			OP_TAP:   addend = (wb.idx == IDX_W'(ORDER - 1)) ? '0 : mem_q[nxt_idx];
			OP_SCALE: addend = '0;
			default:  addend = '0;
		endcase
	end

	lpcsyn_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.addend (addend),
		.wb     (wb),
		.result (mac_result),
		.sample (mac_sample),
		.clip   (mac_clip)
	);

	// Filter memory and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) begin
				mem_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (wb.vld && wb.op == OP_TAP) begin
				mem_q[wb.idx] <= mac_result;
			end
			if (wb.vld && wb.op == OP_SCALE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// y and output sample registers
	always_ff @(posedge clk) begin
		if (wb.vld && wb.op == OP_GAIN) begin
			y_q <= mac_result;
		end
		if (wb.vld && wb.op == OP_SCALE) begin
			speech_q <= mac_sample;
			clip_q   <= mac_clip;
		end
	end

	assign out_valid     = out_valid_q;
	assign speech_sample = speech_q;
	assign clipped       = clip_q;

endmodule

// ===== rtl/lpcsyn_mac.sv =====
// Shared multiply, round, accumulate and saturate unit of the synthesis filter.
// Depends on lpcsyn_pkg.
module lpcsyn_mac import lpcsyn_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_tag_t                   issue,
	input  logic signed [MUL_A_W-1:0]  mul_a,
	input  logic signed [MUL_B_W-1:0]  mul_b,
	input  logic signed [DATA_W-1:0]   addend,
	output mac_tag_t                   wb,
	output logic signed [DATA_W-1:0]   result,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       clip
);

	localparam int SUM_W = PROD_W + 2;

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	mac_tag_t                 tag_s1;
	logic [3:0]               sh;
	logic signed [PROD_W:0]   biased;
	logic signed [PROD_W:0]   rounded;
	logic signed [SUM_W-1:0]  sum;
	logic                     ovf32;
	logic                     ovf16;

	assign prod = mul_a * mul_b;

	// Stage 1: registered product and its tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.vld) begin
			prod_s1 <= prod;
		end
	end

	// Stage 2: round half up, then add the addend for gain, subtract it for a tap, none for scale
	always_comb begin
		case (tag_s1.op)
			OP_GAIN:  sh = SH_GAIN;
			OP_TAP:   sh = SH_TAP;
			OP_SCALE: sh = SH_SCALE;
			default:  sh = SH_TAP;
		endcase
		biased  = (PROD_W+1)'(prod_s1) + ((PROD_W+1)'(1) <<< (sh - 4'd1));
		rounded = biased >>> sh;
		case (tag_s1.op)
			OP_GAIN:  sum = SUM_W'(addend) + SUM_W'(rounded);
			OP_TAP:   sum = SUM_W'(addend) - SUM_W'(rounded);
			OP_SCALE: sum = SUM_W'(rounded);
			default:  sum = SUM_W'(rounded);
		endcase
	end

	// Saturation to 32 and 16 bits
	assign ovf32 = !((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]));
	assign ovf16 = !((&sum[SUM_W-1:SAMPLE_W-1]) || !(|sum[SUM_W-1:SAMPLE_W-1]));

	always_comb begin
		if (ovf32) begin
			result = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			result = sum[DATA_W-1:0];
		end
		if (ovf16) begin
			sample = sum[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
				: {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			sample = sum[SAMPLE_W-1:0];
		end
	end

	assign clip = ovf16;
	assign wb   = tag_s1;

endmodule

// ===== rtl/lpcsyn_ctrl.sv =====
// Sequencer that issues the gain, tap and output scale operations of one sample.
// Depends on lpcsyn_pkg.
module lpcsyn_ctrl import lpcsyn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_busy,
	output logic     in_ready,
	output mac_tag_t issue
);

	state_t           state_q;
	state_t           state_nxt;
	logic [IDX_W-1:0] tap_q;
	logic [IDX_W-1:0] tap_nxt;

	// State and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_nxt;
			tap_q   <= tap_nxt;
		end
	end

	// Next state and issue
	always_comb begin
		state_nxt = state_q;
		tap_nxt   = tap_q;
		in_ready  = 1'b0;
		issue.vld = 1'b0;
		issue.op  = OP_GAIN;
		issue.idx = tap_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = ST_GAIN;
				end
			end
			ST_GAIN: begin
				issue.vld = 1'b1;
				issue.op  = OP_GAIN;
				state_nxt = ST_HOLD;
			end
			// y is written back here; taps need it as an operand
			ST_HOLD: begin
				tap_nxt   = '0;
				state_nxt = ST_TAP;
			end
			ST_TAP: begin
				issue.vld = 1'b1;
				issue.op  = OP_TAP;
				if (tap_q == IDX_W'(ORDER - 1)) begin
					state_nxt = ST_SCALE;
				end else begin
					tap_nxt = tap_q + 1'b1;
				end
			end
			ST_SCALE: begin
				if (!out_busy) begin
					issue.vld = 1'b1;
					issue.op  = OP_SCALE;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
